>>> src/assert_macros.svh
// assertion macros shared by the terminal writer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition implies property in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// condition implies property in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

>>> src/ttw_pkg.sv
// types, codes and constants of the text terminal writer
`timescale 1ns / 1ps

package ttw_pkg;

   // default screen geometry
   localparam int ROWS_DEF = 25;
   localparam int COLS_DEF = 80;

   // field widths
   localparam int REQ_TYPE_W = 3;
   localparam int CHAR_W     = 8;
   localparam int ATTR_W     = 8;
   localparam int POS_W      = 11;
   localparam int CELL_W     = CHAR_W + ATTR_W;

   // request codes
   localparam logic [REQ_TYPE_W-1:0] REQ_PUT   = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_BACK  = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_SET   = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_READ  = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR = 3'd4;

   // character and attribute constants
   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'd0;
   localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [CHAR_W-1:0]     character;
      logic [ATTR_W-1:0]     attribute;
      logic [POS_W-1:0]      position;
   } request_type;

   typedef struct packed {
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attr;
      logic [POS_W-1:0]  cursor_now;
   } result_type;

   // top level to engine
   typedef struct packed {
      logic              start;
      logic              taken;
      logic [ATTR_W-1:0] clear_attr;
      request_type       request;
   } eng_cmd_type;

   // engine to top level
   typedef struct packed {
      logic       idle;
      logic       done;
      result_type result;
   } eng_status_type;

endpackage

>>> src/ttw_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps

interface ttw_req_if;
   logic                             valid;
   logic                             ready;
   logic [ttw_pkg::REQ_TYPE_W-1:0]   req_type;
   logic [ttw_pkg::CHAR_W-1:0]       character;
   logic [ttw_pkg::ATTR_W-1:0]       attribute;
   logic [ttw_pkg::POS_W-1:0]        position;

   modport source (output valid, output req_type, output character, output attribute,
                   output position, input ready);
   modport sink   (input valid, input req_type, input character, input attribute,
                   input position, output ready);
endinterface

interface ttw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ttw_pkg::CHAR_W-1:0]  cell_char;
   logic [ttw_pkg::ATTR_W-1:0]  cell_attr;
   logic [ttw_pkg::POS_W-1:0]   cursor_now;

   modport source (output valid, output cell_char, output cell_attr, output cursor_now,
                   input ready);
   modport sink   (input valid, input cell_char, input cell_attr, input cursor_now,
                   output ready);
endinterface

>>> src/ttw_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> src/ttw_engine.sv
// sequencer that owns the cell memory and the cursor
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ttw_engine #(
   parameter int ROWS = ttw_pkg::ROWS_DEF,
   parameter int COLS = ttw_pkg::COLS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  ttw_pkg::eng_cmd_type    cmd,
   output ttw_pkg::eng_status_type status
);

   localparam int CELLS  = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CUR_W  = $clog2(CELLS + 1);
   localparam int EXT_W  = CUR_W + ttw_pkg::POS_W;

   localparam logic [CUR_W-1:0]  CUR_CELLS    = CUR_W'(CELLS);
   localparam logic [CUR_W-1:0]  CUR_LAST_ROW = CUR_W'(CELLS - COLS);
   localparam logic [CUR_W-1:0]  CUR_COLS     = CUR_W'(COLS);
   localparam logic [CUR_W-1:0]  CUR_ONE      = CUR_W'(1);
   localparam logic [ADDR_W-1:0] A_COLS       = ADDR_W'(COLS);
   localparam logic [ADDR_W-1:0] A_SCROLL_END = ADDR_W'(CELLS - COLS);
   localparam logic [ADDR_W-1:0] A_LAST       = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] A_ONE        = ADDR_W'(1);
   localparam logic [EXT_W-1:0]  EXT_CELLS    = EXT_W'(CELLS);

   typedef enum logic [7:0] {
      S_CLEAR     = 8'b0000_0001,
      S_IDLE      = 8'b0000_0010,
      S_NL_SEARCH = 8'b0000_0100,
      S_SCROLL    = 8'b0000_1000,
      S_BLANK     = 8'b0001_0000,
      S_PUT       = 8'b0010_0000,
      S_READ_WAIT = 8'b0100_0000,
      S_DONE      = 8'b1000_0000
   } state_type;

   state_type                    state_ff, state_in;
   logic [CUR_W-1:0]             cursor_ff, cursor_in;
   logic [CUR_W-1:0]             base_ff, base_in;
   logic [ADDR_W-1:0]            cnt_ff, cnt_in;
   logic                         put_after_ff, put_after_in;
   logic                         report_ff, report_in;
   logic [ttw_pkg::ATTR_W-1:0]   fill_ff, fill_in;
   logic [ttw_pkg::CHAR_W-1:0]   put_char_ff, put_char_in;
   logic [ttw_pkg::ATTR_W-1:0]   put_attr_ff, put_attr_in;
   logic [ttw_pkg::CHAR_W-1:0]   rd_char_ff, rd_char_in;
   logic [ttw_pkg::ATTR_W-1:0]   rd_attr_ff, rd_attr_in;

   logic                         ram_we;
   logic [ADDR_W-1:0]            ram_waddr;
   logic [ttw_pkg::CELL_W-1:0]   ram_wdata;
   logic                         ram_re;
   logic [ADDR_W-1:0]            ram_raddr;
   logic [ttw_pkg::CELL_W-1:0]   ram_rdata;

   logic [CUR_W-1:0]             cursor_dec;
   logic [EXT_W-1:0]             pos_ext;
   logic [EXT_W-1:0]             cursor_ext;

   assign cursor_dec = cursor_ff - CUR_ONE;
   assign pos_ext    = {{CUR_W{1'b0}}, cmd.request.position};
   assign cursor_ext = {{ttw_pkg::POS_W{1'b0}}, cursor_ff};

   // cell memory
   ttw_ram #(
      .WIDTH (ttw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_cells (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // sequencer next state and memory access
   always_comb begin
      state_in     = state_ff;
      cursor_in    = cursor_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      put_after_in = put_after_ff;
      report_in    = report_ff;
      fill_in      = fill_ff;
      put_char_in  = put_char_ff;
      put_attr_in  = put_attr_ff;
      rd_char_in   = rd_char_ff;
      rd_attr_in   = rd_attr_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;

      unique case (state_ff)
         // blank sweep after reset or for clear screen
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = {fill_ff, ttw_pkg::BLANK_CHAR};
            cnt_in    = cnt_ff + A_ONE;
            if (cnt_ff == A_LAST) begin
               cnt_in   = '0;
               state_in = report_ff ? S_DONE : S_IDLE;
            end
         end

         // decode a new request
         S_IDLE: begin
            if (cmd.start) begin
               put_char_in  = cmd.request.character;
               put_attr_in  = cmd.request.attribute;
               rd_char_in   = '0;
               rd_attr_in   = '0;
               put_after_in = 1'b0;
               cnt_in       = '0;
               unique case (cmd.request.req_type)
                  ttw_pkg::REQ_PUT: begin
                     if (cmd.request.character == ttw_pkg::NEWLINE_CODE) begin
                        if (cursor_ff >= CUR_LAST_ROW) begin
                           state_in = S_SCROLL;
                        end else begin
                           base_in  = CUR_COLS;
                           state_in = S_NL_SEARCH;
                        end
                     end else if (cursor_ff == CUR_CELLS) begin
                        put_after_in = 1'b1;
                        state_in     = S_SCROLL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = cursor_ff[ADDR_W-1:0];
                        ram_wdata = {cmd.request.attribute, cmd.request.character};
                        cursor_in = cursor_ff + CUR_ONE;
                        state_in  = S_DONE;
                     end
                  end
                  ttw_pkg::REQ_BACK: begin
                     if (cursor_ff != '0) begin
                        ram_we    = 1'b1;
                        ram_waddr = cursor_dec[ADDR_W-1:0];
                        ram_wdata = {cmd.clear_attr, ttw_pkg::BLANK_CHAR};
                        cursor_in = cursor_dec;
                     end
                     state_in = S_DONE;
                  end
                  ttw_pkg::REQ_SET: begin
                     if (pos_ext > EXT_CELLS) begin
                        cursor_in = CUR_CELLS;
                     end else begin
                        cursor_in = pos_ext[CUR_W-1:0];
                     end
                     state_in = S_DONE;
                  end
                  ttw_pkg::REQ_READ: begin
                     if (pos_ext < EXT_CELLS) begin
                        ram_re    = 1'b1;
                        ram_raddr = pos_ext[ADDR_W-1:0];
                        state_in  = S_READ_WAIT;
                     end else begin
                        state_in  = S_DONE;
                     end
                  end
                  ttw_pkg::REQ_CLEAR: begin
                     fill_in   = cmd.clear_attr;
                     report_in = 1'b1;
                     state_in  = S_CLEAR;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         // walk row starts until one lies past the cursor
         S_NL_SEARCH: begin
            if (base_ff > cursor_ff) begin
               cursor_in = base_ff;
               state_in  = S_DONE;
            end else begin
               base_in = base_ff + CUR_COLS;
            end
         end

         // copy each cell one row up, each write taking the data read on the cycle before
         S_SCROLL: begin
            if (cnt_ff != A_SCROLL_END) begin
               ram_re    = 1'b1;
               ram_raddr = cnt_ff + A_COLS;
               cnt_in    = cnt_ff + A_ONE;
            end else begin
               state_in  = S_BLANK;
            end
            if (cnt_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = cnt_ff - A_ONE;
               ram_wdata = ram_rdata;
            end
         end

         // blank the last row
         S_BLANK: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff;
            ram_wdata = {cmd.clear_attr, ttw_pkg::BLANK_CHAR};
            cnt_in    = cnt_ff + A_ONE;
            if (cnt_ff == A_LAST) begin
               cnt_in    = '0;
               cursor_in = CUR_LAST_ROW;
               state_in  = put_after_ff ? S_PUT : S_DONE;
            end
         end

         // character write after an end-of-screen scroll
         S_PUT: begin
            ram_we    = 1'b1;
            ram_waddr = cursor_ff[ADDR_W-1:0];
            ram_wdata = {put_attr_ff, put_char_ff};
            cursor_in = cursor_ff + CUR_ONE;
            state_in  = S_DONE;
         end

         // capture read data
         S_READ_WAIT: begin
            rd_char_in = ram_rdata[ttw_pkg::CHAR_W-1:0];
            rd_attr_in = ram_rdata[ttw_pkg::CELL_W-1:ttw_pkg::CHAR_W];
            state_in   = S_DONE;
         end

         // hold the result until the output register takes it
         S_DONE: begin
            if (cmd.taken) begin
               report_in = 1'b0;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cursor_ff    <= '0;
         cnt_ff       <= '0;
         put_after_ff <= 1'b0;
         report_ff    <= 1'b0;
         fill_ff      <= ttw_pkg::RESET_ATTR;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         cnt_ff       <= cnt_in;
         put_after_ff <= put_after_in;
         report_ff    <= report_in;
         fill_ff      <= fill_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      put_char_ff <= put_char_in;
      put_attr_ff <= put_attr_in;
      rd_char_ff  <= rd_char_in;
      rd_attr_ff  <= rd_attr_in;
   end

   // status back to the top level
   assign status.idle              = (state_ff == S_IDLE);
   assign status.done              = (state_ff == S_DONE);
   assign status.result.cell_char  = rd_char_ff;
   assign status.result.cell_attr  = rd_attr_ff;
   assign status.result.cursor_now = cursor_ext[ttw_pkg::POS_W-1:0];

   `ASSERT_IMPLIES(a_cursor_range, clock, reset, 1'b1, cursor_ff <= CUR_CELLS)
   `ASSERT_IMPLIES(a_start_idle, clock, reset, cmd.start, state_ff == S_IDLE)
   `ASSERT_IMPLIES(a_no_rw_overlap, clock, reset, ram_we && ram_re, ram_waddr != ram_raddr)
   `ASSERT_NEXT(a_read_settles, clock, reset, state_ff == S_READ_WAIT, state_ff == S_DONE)

endmodule

>>> src/text_mode_terminal_writer.sv
// text terminal writer top level: handshakes, control register, output register
//
// channel   dir  handshake      payload
// req_bus   in   valid/ready    req_type, character, attribute, position
// rsp_bus   out  valid/ready    cell_char, cell_attr, cursor_now
// csr_*     in   csr_we         csr_wdata (clear attribute)
//
// put, backspace, set cursor, unused codes: S_IDLE to S_DONE; read cell: via S_READ_WAIT
// newline: S_NL_SEARCH walks row starts (up to ROWS-1) to the next one, or a scroll
// scroll: S_SCROLL copy and S_BLANK blank share one memory write port (then S_PUT for a put)
// clear screen: all ROWS*COLS cells, one cell write per cycle
// after reset a blanking pass over all ROWS*COLS cells runs before req_bus.ready rises
// a finished result waits in the output register while the next request starts
`timescale 1ns / 1ps
`include "assert_macros.svh"

module text_mode_terminal_writer #(
   parameter int ROWS = ttw_pkg::ROWS_DEF,
   parameter int COLS = ttw_pkg::COLS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   ttw_req_if.sink                    req_bus,
   ttw_rsp_if.source                  rsp_bus,
   input  logic                       csr_we,
   input  logic [ttw_pkg::ATTR_W-1:0] csr_wdata
);

   ttw_pkg::eng_cmd_type        eng_cmd;
   ttw_pkg::eng_status_type     eng_status;
   logic [ttw_pkg::ATTR_W-1:0]  clear_attr_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   ttw_pkg::result_type         rsp_data_ff;
   logic                        load;

   // clear attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_attr_ff <= ttw_pkg::RESET_ATTR;
      end else if (csr_we) begin
         clear_attr_ff <= csr_wdata;
      end
   end

   // request side
   assign req_bus.ready                 = eng_status.idle;
   assign eng_cmd.start                 = req_bus.valid & req_bus.ready;
   assign eng_cmd.clear_attr            = clear_attr_ff;
   assign eng_cmd.request.req_type      = req_bus.req_type;
   assign eng_cmd.request.character     = req_bus.character;
   assign eng_cmd.request.attribute     = req_bus.attribute;
   assign eng_cmd.request.position      = req_bus.position;
   assign eng_cmd.taken                 = load;

   ttw_engine #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .cmd    (eng_cmd),
      .status (eng_status)
   );

   // output register
   assign load         = eng_status.done & (~rsp_valid_ff | rsp_bus.ready);
   assign rsp_valid_in = load | (rsp_valid_ff & ~rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= eng_status.result;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.cell_char  = rsp_data_ff.cell_char;
   assign rsp_bus.cell_attr  = rsp_data_ff.cell_attr;
   assign rsp_bus.cursor_now = rsp_data_ff.cursor_now;

   `ASSERT_NEXT(a_result_held, clock, reset, eng_status.done && !eng_cmd.taken, eng_status.done)
   `ASSERT_IMPLIES(a_ready_not_done, clock, reset, req_bus.ready, !eng_status.done)
   `ASSERT_NEXT(a_load_shows, clock, reset, load, rsp_bus.valid)

endmodule

>>> test/tb_text_mode_terminal_writer.sv
// self-checking testbench for the text terminal writer
`timescale 1ns / 1ps

module tb_text_mode_terminal_writer;

   localparam int ROWS  = ttw_pkg::ROWS_DEF;
   localparam int COLS  = ttw_pkg::COLS_DEF;
   localparam int CELLS = ROWS * COLS;
   localparam logic [ttw_pkg::POS_W-1:0] POS_MAX       = '1;
   localparam logic [ttw_pkg::POS_W-1:0] POS_CELLS     = CELLS[ttw_pkg::POS_W-1:0];
   localparam logic [ttw_pkg::POS_W-1:0] POS_LAST_CELL = POS_CELLS - 1'b1;
   localparam logic [ttw_pkg::POS_W-1:0] POS_LAST_ROW  = POS_CELLS - COLS[ttw_pkg::POS_W-1:0];

   // request codes the block does not act on
   localparam logic [ttw_pkg::REQ_TYPE_W-1:0] REQ_SPARE_FIRST = 3'd5;
   localparam logic [ttw_pkg::REQ_TYPE_W-1:0] REQ_SPARE_LAST  = 3'd7;

   // a clear or scroll walks every cell; worst run is every request that slow, every wait long
   localparam int unsigned CYCLE_LIMIT = 20_000_000;
   localparam int RANDOM_PER_PHASE = 500;
   localparam int PHASES = 4;

   // screen predictor plus queue of responses still to come
   class terminal_scoreboard;
      logic [ttw_pkg::CELL_W-1:0] screen [CELLS];
      int unsigned                cursor_pos;
      logic [ttw_pkg::ATTR_W-1:0] clear_attr;
      ttw_pkg::result_type        awaited_results [$];
      int unsigned                error_count;

      function new();
         foreach (screen[i]) screen[i] = {ttw_pkg::RESET_ATTR, ttw_pkg::BLANK_CHAR};
         cursor_pos  = 0;
         clear_attr  = ttw_pkg::RESET_ATTR;
         error_count = 0;
      endfunction

      function void blank_cells(int unsigned first, int unsigned count);
         for (int unsigned i = first; i < first + count; i++)
            screen[i] = {clear_attr, ttw_pkg::BLANK_CHAR};
      endfunction

      // move every row up, blank the last one, cursor to its start
      function void scroll_up();
         for (int unsigned i = 0; i + COLS < CELLS; i++)
            screen[i] = screen[i + COLS];
         blank_cells(CELLS - COLS, COLS);
         cursor_pos = CELLS - COLS;
      endfunction

      // update the screen for an accepted request and queue its response
      function void apply_request(ttw_pkg::request_type r);
         ttw_pkg::result_type want;
         want = '0;
         case (r.req_type)
            ttw_pkg::REQ_PUT: begin
               if (r.character == ttw_pkg::NEWLINE_CODE) begin
                  if (cursor_pos / COLS >= ROWS - 1)
                     scroll_up();
                  else
                     cursor_pos = (cursor_pos / COLS + 1) * COLS;
               end else begin
                  if (cursor_pos >= CELLS)
                     scroll_up();
                  screen[cursor_pos] = {r.attribute, r.character};
                  cursor_pos++;
               end
            end
            ttw_pkg::REQ_BACK: begin
               if (cursor_pos != 0) begin
                  cursor_pos--;
                  screen[cursor_pos] = {clear_attr, ttw_pkg::BLANK_CHAR};
               end
            end
            ttw_pkg::REQ_SET: begin
               cursor_pos = (r.position > CELLS) ? CELLS : r.position;
            end
            ttw_pkg::REQ_READ: begin
               if (r.position < CELLS) begin
                  want.cell_char = screen[r.position][ttw_pkg::CHAR_W-1:0];
                  want.cell_attr = screen[r.position][ttw_pkg::CELL_W-1:ttw_pkg::CHAR_W];
               end
            end
            ttw_pkg::REQ_CLEAR: begin
               blank_cells(0, CELLS);
            end
            default: ;
         endcase
         want.cursor_now = cursor_pos[ttw_pkg::POS_W-1:0];
         awaited_results.push_back(want);
      endfunction

      // compare a response with the oldest one awaited
      function void check_response(ttw_pkg::result_type got);
         ttw_pkg::result_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t unexpected response: expected none, actual char %0h attr %0h cursor %0d",
                     $time, got.cell_char, got.cell_attr, got.cursor_now);
            error_count++;
            return;
         end
         want = awaited_results.pop_front();
         if (got.cell_char !== want.cell_char) begin
            $display("%0t cell_char: expected %0h, actual %0h",
                     $time, want.cell_char, got.cell_char);
            error_count++;
         end
         if (got.cell_attr !== want.cell_attr) begin
            $display("%0t cell_attr: expected %0h, actual %0h",
                     $time, want.cell_attr, got.cell_attr);
            error_count++;
         end
         if (got.cursor_now !== want.cursor_now) begin
            $display("%0t cursor_now: expected %0d, actual %0d",
                     $time, want.cursor_now, got.cursor_now);
            error_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [ttw_pkg::ATTR_W-1:0] csr_wdata;
   int unsigned cycle_count;
   int req_calm_left;
   int rsp_calm_left;
   terminal_scoreboard sb;

   ttw_req_if req_bus ();
   ttw_rsp_if rsp_bus ();

   text_mode_terminal_writer #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // wait in cycles before the next request or response; runs of zero now and then
   function automatic int draw_wait(ref int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 49) == 0) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 19);
   endfunction

   // random cell position between two bounds
   function automatic logic [ttw_pkg::POS_W-1:0] draw_pos(int unsigned lo, int unsigned hi);
      int unsigned v;
      v = $urandom_range(lo, hi);
      return v[ttw_pkg::POS_W-1:0];
   endfunction

   function automatic ttw_pkg::request_type make_request(
         logic [ttw_pkg::REQ_TYPE_W-1:0] kind,
         logic [ttw_pkg::CHAR_W-1:0] ch,
         logic [ttw_pkg::ATTR_W-1:0] attr,
         logic [ttw_pkg::POS_W-1:0] pos);
      ttw_pkg::request_type r;
      r.req_type  = kind;
      r.character = ch;
      r.attribute = attr;
      r.position  = pos;
      return r;
   endfunction

   // mostly text runs with reads near the cursor, some moves, rare clears
   function automatic ttw_pkg::request_type random_request();
      ttw_pkg::request_type r;
      int unsigned pick;
      int unsigned reach;
      int unsigned draw;
      draw = $urandom();
      r = make_request(ttw_pkg::REQ_PUT, draw[ttw_pkg::CHAR_W-1:0],
                       draw[ttw_pkg::CHAR_W+ttw_pkg::ATTR_W-1:ttw_pkg::CHAR_W],
                       draw_pos(0, POS_MAX));
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
         r.req_type = ttw_pkg::REQ_PUT;
      end else if (pick < 63) begin
         r.character = ttw_pkg::NEWLINE_CODE;
      end else if (pick < 71) begin
         r.req_type = ttw_pkg::REQ_BACK;
      end else if (pick < 79) begin
         r.req_type = ttw_pkg::REQ_SET;
         case ($urandom_range(0, 5))
            0: r.position = draw_pos(CELLS - 10, POS_MAX);
            1: begin
               draw = $urandom_range(0, ROWS - 1) * COLS;
               r.position = draw[ttw_pkg::POS_W-1:0];
            end
            default: r.position = draw_pos(0, CELLS);
         endcase
      end else if (pick < 96) begin
         r.req_type = ttw_pkg::REQ_READ;
         if (sb.cursor_pos > 0 && $urandom_range(0, 1) == 1) begin
            reach = (sb.cursor_pos < 40) ? sb.cursor_pos : 40;
            draw = sb.cursor_pos - $urandom_range(1, reach);
            r.position = draw[ttw_pkg::POS_W-1:0];
         end
      end else if (pick < 99) begin
         draw = $urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST);
         r.req_type = draw[ttw_pkg::REQ_TYPE_W-1:0];
      end else begin
         r.req_type = ttw_pkg::REQ_CLEAR;
      end
      return r;
   endfunction

   // drive one request and predict its response once accepted
   task automatic send_request(ttw_pkg::request_type r);
      int gap;
      gap = draw_wait(req_calm_left);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.req_type  <= r.req_type;
      req_bus.character <= r.character;
      req_bus.attribute <= r.attribute;
      req_bus.position  <= r.position;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.apply_request(r);
   endtask

   // take responses with random stalls
   task automatic collect_responses();
      int stall;
      ttw_pkg::result_type got;
      forever begin
         stall = draw_wait(rsp_calm_left);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_bus.valid && rsp_bus.ready)) @(posedge clock);
         got.cell_char  = rsp_bus.cell_char;
         got.cell_attr  = rsp_bus.cell_attr;
         got.cursor_now = rsp_bus.cursor_now;
         sb.check_response(got);
      end
   endtask

   // stop sending and let every awaited response arrive
   task automatic drain_requests();
      req_bus.valid <= 1'b0;
      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_clear_attr(logic [ttw_pkg::ATTR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.clear_attr = value;
   endtask

   initial begin
      logic [ttw_pkg::ATTR_W-1:0] attr_value;
      int unsigned attr_draw;
      sb = new();
      req_calm_left = 0;
      rsp_calm_left = 0;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.req_type  <= ttw_pkg::REQ_PUT;
      req_bus.character <= '0;
      req_bus.attribute <= '0;
      req_bus.position  <= '0;
      rsp_bus.ready     <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      fork
         collect_responses();
      join_none

      // reset contents, reads at and past the last cell
      send_request(make_request(ttw_pkg::REQ_READ, 8'h00, 8'h00, 11'd0));
      send_request(make_request(ttw_pkg::REQ_READ, 8'h00, 8'h00, POS_LAST_CELL));
      send_request(make_request(ttw_pkg::REQ_READ, 8'hFF, 8'hFF, POS_CELLS));
      send_request(make_request(ttw_pkg::REQ_READ, 8'h00, 8'h00, POS_MAX));
      // extreme character and attribute, then read the all-ones cell back
      send_request(make_request(ttw_pkg::REQ_PUT, 8'h00, 8'h00, 11'd0));
      send_request(make_request(ttw_pkg::REQ_PUT, 8'hFF, 8'hFF, POS_MAX));
      send_request(make_request(ttw_pkg::REQ_READ, 8'h00, 8'h00, 11'd1));
      // newline mid screen, backspace across a row start and at zero
      send_request(make_request(ttw_pkg::REQ_PUT, ttw_pkg::NEWLINE_CODE, 8'h5A, 11'd0));
      send_request(make_request(ttw_pkg::REQ_BACK, 8'h00, 8'h00, 11'd0));
      send_request(make_request(ttw_pkg::REQ_SET, 8'h00, 8'h00, 11'd0));
      send_request(make_request(ttw_pkg::REQ_BACK, 8'h00, 8'h00, 11'd0));
      // cursor saturates past the end, put there scrolls first
      send_request(make_request(ttw_pkg::REQ_SET, 8'h00, 8'h00, POS_MAX));
      send_request(make_request(ttw_pkg::REQ_PUT, 8'h41, 8'h1E, 11'd0));
      send_request(make_request(ttw_pkg::REQ_READ, 8'h00, 8'h00, POS_LAST_ROW));
      // newline past the end scrolls, also after a put into the last cell
      send_request(make_request(ttw_pkg::REQ_SET, 8'h00, 8'h00, POS_CELLS));
      send_request(make_request(ttw_pkg::REQ_PUT, ttw_pkg::NEWLINE_CODE, 8'h00, 11'd0));
      send_request(make_request(ttw_pkg::REQ_SET, 8'h00, 8'h00, POS_LAST_CELL));
      send_request(make_request(ttw_pkg::REQ_PUT, 8'h42, 8'hC3, 11'd0));
      send_request(make_request(ttw_pkg::REQ_PUT, ttw_pkg::NEWLINE_CODE, 8'h00, 11'd0));
      // backspace from past the end
      send_request(make_request(ttw_pkg::REQ_SET, 8'h00, 8'h00, POS_CELLS));
      send_request(make_request(ttw_pkg::REQ_BACK, 8'h00, 8'h00, 11'd0));
      // spare codes change nothing
      for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
         send_request(make_request(k[ttw_pkg::REQ_TYPE_W-1:0], 8'hFF, 8'hFF, POS_MAX));
      send_request(make_request(ttw_pkg::REQ_CLEAR, 8'h00, 8'h00, 11'd0));
      send_request(make_request(ttw_pkg::REQ_READ, 8'h00, 8'h00, POS_LAST_ROW));
      drain_requests();

      // random phases, each under its own clear attribute
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph == 0) begin
            attr_value = 8'h00;
         end else if (ph == 1) begin
            attr_value = 8'hFF;
         end else begin
            attr_draw  = $urandom_range(1, 254);
            attr_value = attr_draw[ttw_pkg::ATTR_W-1:0];
         end
         write_clear_attr(attr_value);
         repeat (RANDOM_PER_PHASE) send_request(random_request());
         drain_requests();
      end

      repeat (10) @(posedge clock);
      if (sb.error_count == 0 && sb.awaited_results.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+src
src/ttw_pkg.sv
src/ttw_if.sv
src/ttw_ram.sv
src/ttw_engine.sv
src/text_mode_terminal_writer.sv
test/tb_text_mode_terminal_writer.sv
